>>> design/tle_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// tle_pkg
// Shared types and constants of the terminal line editor: result codes,
// control characters, register indexes and the sequencer states.
// ============================================================================
package tle_pkg;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_CHAR = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam logic REG_ECHO_ENABLE = 1'b0;
    localparam logic REG_TAKE_LIMIT  = 1'b1;

    localparam logic [5:0] TAKE_LIMIT_RESET = 6'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO_CHAR,
        ST_ERASE,
        ST_ECHO_NL,
        ST_READ,
        ST_CHAR,
        ST_END
    } state_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [4:0] line_length;
        logic       lost_chars;
        logic       last;
    } result_t;

endpackage

>>> design/tle_store.sv
`timescale 1ns / 1ps
// ============================================================================
// tle_store
// Line store: single-port synchronous RAM, one write or one read per cycle,
// registered read data that holds until the next read.
// ============================================================================
module tle_store #(
    parameter int DEPTH = 31,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic          re,
    input  logic [AW-1:0] addr,
    input  logic [7:0]    wdata,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/tle_outbuf.sv
`timescale 1ns / 1ps
// ============================================================================
// tle_outbuf
// Result output register: holds one result item for the m_ channel and
// takes a new one in the cycle the current one transfers.
// ============================================================================
module tle_outbuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tle_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tle_pkg::result_t out_data
);

    logic             valid_reg;
    logic             valid_next;
    tle_pkg::result_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> design/terminal_line_editor_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// terminal_line_editor_unit
// Canonical-mode line editor: edits a line in a RAM and streams it out.
// ============================================================================
// Bytes are taken one at a time; s_ready is high only while the sequencer is
// idle. An appended or ignored byte keeps it idle unless echoed; an erase
// with echo sends backspace, space, backspace. A line end sends the newline
// echo if enabled, the n delivered characters, then the end status: the store
// is one single-port RAM read one character per cycle unless output stalls.
// A final result waiting in the output register does not block the next byte.
// ============================================================================
module terminal_line_editor_unit #(
    parameter int LINE_MAX = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_data_byte,
    output logic [4:0]  m_line_length,
    output logic        m_lost_chars,
    output logic        m_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH = LINE_MAX - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(LINE_MAX);

    tle_pkg::state_t state_reg, state_next;

    logic          echo_reg;
    logic [5:0]    take_reg;
    logic [CW-1:0] fill_reg, fill_next;
    logic          trunc_reg, trunc_next;
    logic          swallow_reg, swallow_next;
    logic [7:0]    byte_reg, byte_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [1:0]    step_reg, step_next;

    logic             ob_valid;
    logic             ob_ready;
    tle_pkg::result_t ob_data;
    tle_pkg::result_t m_data;

    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_rdata;

    logic          accept;
    logic          is_lf;
    logic          is_eol;
    logic          is_erase;
    logic          is_nul;
    logic          skip_lf;
    logic          has_room;
    logic [6:0]    fill_wide;
    logic [6:0]    tl_m1;
    logic          clip;
    logic [CW-1:0] n_cur;
    logic [6:0]    n_wide;
    logic          cfg_wr;

    // ---------------- configuration ----------------
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_reg <= 1'b0;
            take_reg <= tle_pkg::TAKE_LIMIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                tle_pkg::REG_ECHO_ENABLE: echo_reg <= pwdata[0];
                tle_pkg::REG_TAKE_LIMIT:  take_reg <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            tle_pkg::REG_ECHO_ENABLE: prdata = 32'(echo_reg);
            tle_pkg::REG_TAKE_LIMIT:  prdata = 32'(take_reg);
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------- byte decode ----------------
    assign s_ready  = (state_reg == tle_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_lf    = (s_rx_byte == tle_pkg::CH_LF);
    assign is_eol   = is_lf || (s_rx_byte == tle_pkg::CH_CR);
    assign is_erase = (s_rx_byte == tle_pkg::CH_BS) || (s_rx_byte == tle_pkg::CH_DEL);
    assign is_nul   = (s_rx_byte == tle_pkg::CH_NUL);
    assign skip_lf  = swallow_reg && is_lf;
    assign has_room = (fill_reg < CW'(DEPTH));

    assign fill_wide = 7'(fill_reg);
    assign tl_m1     = 7'(take_reg) - 7'd1;
    assign clip      = (take_reg != 6'd0) && (fill_wide > tl_m1);
    assign n_cur     = (take_reg == 6'd0) ? '0 : (clip ? tl_m1[CW-1:0] : fill_reg);
    assign n_wide    = 7'(n_reg);

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tle_pkg::ST_IDLE: begin
                if (accept && !skip_lf) begin
                    if (is_eol) begin
                        if (echo_reg) begin
                            state_next = tle_pkg::ST_ECHO_NL;
                        end else if (n_cur != '0) begin
                            state_next = tle_pkg::ST_READ;
                        end else begin
                            state_next = tle_pkg::ST_END;
                        end
                    end else if (is_erase) begin
                        if (echo_reg && fill_reg != '0) begin
                            state_next = tle_pkg::ST_ERASE;
                        end
                    end else if (!is_nul && has_room && echo_reg) begin
                        state_next = tle_pkg::ST_ECHO_CHAR;
                    end
                end
            end
            tle_pkg::ST_ECHO_CHAR: begin
                if (ob_ready) begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_ERASE: begin
                if (ob_ready && step_reg == 2'd2) begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            tle_pkg::ST_ECHO_NL: begin
                if (ob_ready) begin
                    state_next = (n_reg != '0) ? tle_pkg::ST_READ : tle_pkg::ST_END;
                end
            end
            tle_pkg::ST_READ: begin
                state_next = tle_pkg::ST_CHAR;
            end
            tle_pkg::ST_CHAR: begin
                if (ob_ready && idx_reg >= n_reg) begin
                    state_next = tle_pkg::ST_END;
                end
            end
            tle_pkg::ST_END: begin
                if (ob_ready) begin
                    state_next = tle_pkg::ST_IDLE;
                end
            end
            default: state_next = tle_pkg::ST_IDLE;
        endcase
    end

    // ---------------- outputs and datapath ----------------
    always_comb begin
        fill_next    = fill_reg;
        trunc_next   = trunc_reg;
        swallow_next = swallow_reg;
        byte_next    = byte_reg;
        n_next       = n_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_addr     = fill_reg[AW-1:0];
        ob_valid     = 1'b0;
        ob_data      = '{kind: tle_pkg::KIND_ECHO, data_byte: 8'd0, line_length: 5'd0,
                         lost_chars: 1'b0, last: 1'b0};
        case (state_reg)
            tle_pkg::ST_IDLE: begin
                if (accept) begin
                    swallow_next = 1'b0;
                    byte_next    = s_rx_byte;
                    step_next    = 2'd0;
                    idx_next     = '0;
                    if (!skip_lf) begin
                        if (is_eol) begin
                            swallow_next = !is_lf;
                            n_next       = n_cur;
                            fill_next    = '0;
                            if (clip) begin
                                trunc_next = 1'b1;
                            end
                        end else if (is_erase) begin
                            if (fill_reg != '0) begin
                                fill_next = fill_reg - CW'(1);
                            end
                        end else if (!is_nul) begin
                            if (has_room) begin
                                mem_we    = 1'b1;
                                fill_next = fill_reg + CW'(1);
                            end else begin
                                trunc_next = 1'b1;
                            end
                        end
                    end
                end
            end
            tle_pkg::ST_ECHO_CHAR: begin
                ob_valid          = 1'b1;
                ob_data.data_byte = byte_reg;
                ob_data.last      = 1'b1;
            end
            tle_pkg::ST_ERASE: begin
                ob_valid          = 1'b1;
                ob_data.data_byte = (step_reg == 2'd1) ? tle_pkg::CH_SP : tle_pkg::CH_BS;
                ob_data.last      = (step_reg == 2'd2);
                if (ob_ready) begin
                    step_next = step_reg + 2'd1;
                end
            end
            tle_pkg::ST_ECHO_NL: begin
                ob_valid          = 1'b1;
                ob_data.data_byte = tle_pkg::CH_LF;
            end
            tle_pkg::ST_READ: begin
                mem_re   = 1'b1;
                mem_addr = idx_reg[AW-1:0];
                idx_next = idx_reg + CW'(1);
            end
            tle_pkg::ST_CHAR: begin
                ob_valid          = 1'b1;
                ob_data.kind      = tle_pkg::KIND_CHAR;
                ob_data.data_byte = mem_rdata;
                if (ob_ready && idx_reg < n_reg) begin
                    mem_re   = 1'b1;
                    mem_addr = idx_reg[AW-1:0];
                    idx_next = idx_reg + CW'(1);
                end
            end
            tle_pkg::ST_END: begin
                ob_valid            = 1'b1;
                ob_data.kind        = tle_pkg::KIND_END;
                ob_data.line_length = n_wide[4:0];
                ob_data.lost_chars  = trunc_reg;
                ob_data.last        = 1'b1;
                if (ob_ready) begin
                    trunc_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tle_pkg::ST_IDLE;
            fill_reg    <= '0;
            trunc_reg   <= 1'b0;
            swallow_reg <= 1'b0;
            idx_reg     <= '0;
            step_reg    <= 2'd0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            trunc_reg   <= trunc_next;
            swallow_reg <= swallow_next;
            idx_reg     <= idx_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        n_reg    <= n_next;
    end

    // ---------------- line store and output register ----------------
    tle_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (s_rx_byte),
        .rdata (mem_rdata)
    );

    tle_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ob_valid),
        .in_ready  (ob_ready),
        .in_data   (ob_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    assign m_kind        = m_data.kind;
    assign m_data_byte   = m_data.data_byte;
    assign m_line_length = m_data.line_length;
    assign m_lost_chars  = m_data.lost_chars;
    assign m_last        = m_data.last;

endmodule

>>> design/tle_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// tle_checker
// Port-level checks of the terminal line editor, bound to the top level.
// ============================================================================
module tle_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_kind,
    input logic [7:0] m_data_byte,
    input logic [4:0] m_line_length,
    input logic       m_lost_chars,
    input logic       m_last
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_data_byte)
            && $stable(m_line_length) && $stable(m_lost_chars) && $stable(m_last))
        else $error("stalled result changed");

    // line end status always closes the byte's results
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == tle_pkg::KIND_END |-> m_last && m_data_byte == 8'd0)
        else $error("line end item malformed");

    // length and lost flag only on line end items
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != tle_pkg::KIND_END |-> m_line_length == 5'd0 && !m_lost_chars)
        else $error("status fields set on non-end item");

    // no new byte while a byte's results are still coming
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input taken before results complete");

endmodule

bind terminal_line_editor_unit tle_checker u_tle_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_kind        (m_kind),
    .m_data_byte   (m_data_byte),
    .m_line_length (m_line_length),
    .m_lost_chars  (m_lost_chars),
    .m_last        (m_last)
);
